FILE: rtl/core/scr_pkg.sv
`timescale 1ns / 1ps

package scr_pkg;

	localparam int CORDIC_STEPS      = 24;
	localparam int CORDIC_SCALE_BITS = 30;
	localparam int CORDIC_ACC_BITS   = 34;
	localparam int CORDIC_STEP_BITS  = 5;
	localparam logic [31:0] CORDIC_GAIN_START = 32'd652032874;

	localparam int ANGLE_BITS   = 16;
	localparam int RESID_BITS   = 14;
	localparam int ANGLE_Z_BITS = 16;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam int MODE_BITS      = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ROTATION_MODE   = 2'd0,
		REG_BACK_AZIMUTH    = 2'd1,
		REG_INCIDENCE_ANGLE = 2'd2
	} cfg_reg_t;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_NE_RT   = 2'd0,
		MODE_RT_NE   = 2'd1,
		MODE_ZNE_LQT = 2'd2,
		MODE_LQT_ZNE = 2'd3
	} rot_mode_t;

	typedef struct packed {
		logic                      en;
		logic [CFG_INDEX_BITS-1:0] index;
		logic [CFG_DATA_BITS-1:0]  data;
	} cfg_write_t;

	function automatic logic [31:0] turn_atan(input logic [CORDIC_STEP_BITS-1:0] step);
		case (step)
			5'd0:  turn_atan = 32'd536870912;
			5'd1:  turn_atan = 32'd316933406;
			5'd2:  turn_atan = 32'd167458907;
			5'd3:  turn_atan = 32'd85004756;
			5'd4:  turn_atan = 32'd42667331;
			5'd5:  turn_atan = 32'd21354465;
			5'd6:  turn_atan = 32'd10679838;
			5'd7:  turn_atan = 32'd5340245;
			5'd8:  turn_atan = 32'd2670163;
			5'd9:  turn_atan = 32'd1335087;
			5'd10: turn_atan = 32'd667544;
			5'd11: turn_atan = 32'd333772;
			5'd12: turn_atan = 32'd166886;
			5'd13: turn_atan = 32'd83443;
			5'd14: turn_atan = 32'd41722;
			5'd15: turn_atan = 32'd20861;
			5'd16: turn_atan = 32'd10430;
			5'd17: turn_atan = 32'd5215;
			5'd18: turn_atan = 32'd2608;
			5'd19: turn_atan = 32'd1304;
			5'd20: turn_atan = 32'd652;
			5'd21: turn_atan = 32'd326;
			5'd22: turn_atan = 32'd163;
			5'd23: turn_atan = 32'd81;
			default: turn_atan = 32'd0;
		endcase
	endfunction

endpackage

FILE: rtl/core/scr_sample_if.sv
`timescale 1ns / 1ps

interface scr_sample_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] comp_a;
	logic signed [SAMPLE_BITS-1:0] comp_b;
	logic signed [SAMPLE_BITS-1:0] comp_c;
	logic                          last_in;

	modport source (output valid, output comp_a, output comp_b, output comp_c,
		output last_in, input ready);
	modport sink (input valid, input comp_a, input comp_b, input comp_c,
		input last_in, output ready);
endinterface

FILE: rtl/core/scr_result_if.sv
`timescale 1ns / 1ps

interface scr_result_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_a;
	logic signed [SAMPLE_BITS-1:0] out_b;
	logic signed [SAMPLE_BITS-1:0] out_c;
	logic                          saturated;
	logic                          last_out;

	modport source (output valid, output out_a, output out_b, output out_c,
		output saturated, output last_out, input ready);
	modport sink (input valid, input out_a, input out_b, input out_c,
		input saturated, input last_out, output ready);
endinterface

FILE: rtl/core/seismic_component_rotator_unit.sv
`timescale 1ns / 1ps

// Three-component seismic rotator. Sample triples enter on the samples channel and
// rotated triples leave on the results channel, both valid/ready, a transfer taking
// place on a clock edge where valid and ready are both high.
// Configuration is a plain write port: index 0 selects the rotation mode, 1 the
// back-azimuth and 2 the incidence angle. Each write to one of these three restarts
// coefficient generation: two rotation units run 24 iterations each, then four cross
// products go through one multiplier, and the coefficient matrix is loaded. While
// this runs, samples.ready is held low.
// An input triple passes the sample, product and output registers before
// results.valid rises; throughput is one triple per cycle while neither coefficient
// generation nor a stalled receiver holds the input.
// When the receiver stalls, the output register holds its result and the two
// earlier stages keep filling, so input stops only once all three are full.
// Reset clears the pipeline and loads the zero-angle coefficients for mode 0,
// so the block accepts samples right after reset.

module seismic_component_rotator_unit
	import scr_pkg::*;
#(
	parameter int SAMPLE_BITS = 24,
	parameter int COEFF_BITS  = 18
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	scr_sample_if.sink                samples,
	scr_result_if.source              results
);

	cfg_write_t                   cfg;
	logic                         coef_busy;
	logic signed [COEFF_BITS-1:0] mat [0:2][0:2];

	assign cfg.en    = cfg_wr_en;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	scr_coef #(.COEFF_BITS(COEFF_BITS)) u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.busy   (coef_busy),
		.mat    (mat)
	);

	scr_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEFF_BITS  (COEFF_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.busy    (coef_busy),
		.mat     (mat),
		.samples (samples),
		.results (results)
	);

	a_cfg_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr_en && (cfg_index == REG_ROTATION_MODE || cfg_index == REG_BACK_AZIMUTH ||
		cfg_index == REG_INCIDENCE_ANGLE)) |=> coef_busy)
		else $error("configuration write did not start coefficient generation");

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		coef_busy |-> !samples.ready)
		else $error("sample accepted while coefficients are being generated");

endmodule

FILE: rtl/core/scr_cordic.sv
`timescale 1ns / 1ps

module scr_cordic
	import scr_pkg::*;
#(
	parameter int COEFF_BITS = 18
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ANGLE_BITS-1:0]        angle,
	output logic signed [COEFF_BITS-1:0] cos_val,
	output logic signed [COEFF_BITS-1:0] sin_val,
	output logic                         done
);

	localparam int F   = COEFF_BITS - 1;
	localparam int SH  = CORDIC_SCALE_BITS - F;
	localparam int ACC = CORDIC_ACC_BITS;
	localparam logic [CORDIC_STEP_BITS-1:0] LAST_STEP = CORDIC_STEP_BITS'(CORDIC_STEPS - 1);
	localparam logic signed [COEFF_BITS-1:0] COEF_MAX = {1'b0, {F{1'b1}}};
	localparam logic signed [ACC-1:0] CMAX_W = {{(ACC-F){1'b0}}, {F{1'b1}}};
	localparam logic signed [ACC-1:0] CMIN_W = -CMAX_W;
	localparam logic signed [ACC-1:0] HALF_W = {{(ACC-1){1'b0}}, 1'b1} << (SH - 1);

	typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cordic_state_t;

	cordic_state_t                 state_q;
	logic [CORDIC_STEP_BITS-1:0]   step_q;
	logic signed [ACC-1:0]         cx_q;
	logic signed [ACC-1:0]         cy_q;
	logic signed [ACC-1:0]         z_q;
	logic [1:0]                    quad_q;
	logic                          zero_q;
	logic signed [COEFF_BITS-1:0]  cos_q;
	logic signed [COEFF_BITS-1:0]  sin_q;
	logic                          done_q;

	logic signed [ACC-1:0]         dx;
	logic signed [ACC-1:0]         dy;
	logic signed [ACC-1:0]         atan_w;
	logic signed [ACC-1:0]         rx;
	logic signed [ACC-1:0]         ry;
	logic signed [COEFF_BITS-1:0]  xv;
	logic signed [COEFF_BITS-1:0]  yv;
	logic signed [COEFF_BITS-1:0]  cos_n;
	logic signed [COEFF_BITS-1:0]  sin_n;

	function automatic logic signed [COEFF_BITS-1:0] clamp_w(input logic signed [ACC-1:0] v);
		if (v > CMAX_W) begin
			clamp_w = COEF_MAX;
		end else if (v < CMIN_W) begin
			clamp_w = -COEF_MAX;
		end else begin
			clamp_w = v[COEFF_BITS-1:0];
		end
	endfunction

	always_comb begin
		dx     = cy_q >>> step_q;
		dy     = cx_q >>> step_q;
		atan_w = $signed({{(ACC-32){1'b0}}, turn_atan(step_q)});
		rx     = (cx_q + HALF_W) >>> SH;
		ry     = (cy_q + HALF_W) >>> SH;
		xv     = zero_q ? COEF_MAX : clamp_w(rx);
		yv     = zero_q ? '0 : clamp_w(ry);
		case (quad_q)
			2'd0: begin
				cos_n = xv;
				sin_n = yv;
			end
			2'd1: begin
				cos_n = -yv;
				sin_n = xv;
			end
			2'd2: begin
				cos_n = -xv;
				sin_n = -yv;
			end
			default: begin
				cos_n = yv;
				sin_n = -xv;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			step_q  <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			z_q     <= '0;
			quad_q  <= '0;
			zero_q  <= 1'b1;
			cos_q   <= COEF_MAX;
			sin_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				state_q <= C_RUN;
				step_q  <= '0;
				cx_q    <= $signed({{(ACC-32){1'b0}}, CORDIC_GAIN_START});
				cy_q    <= '0;
				z_q     <= $signed({{(ACC-RESID_BITS-ANGLE_Z_BITS){1'b0}},
					angle[RESID_BITS-1:0], {ANGLE_Z_BITS{1'b0}}});
				quad_q  <= angle[ANGLE_BITS-1 -: 2];
				zero_q  <= (angle[RESID_BITS-1:0] == '0);
			end else begin
				case (state_q)
					C_RUN: begin
						if (!z_q[ACC-1]) begin
							cx_q <= cx_q - dx;
							cy_q <= cy_q + dy;
							z_q  <= z_q - atan_w;
						end else begin
							cx_q <= cx_q + dx;
							cy_q <= cy_q - dy;
							z_q  <= z_q + atan_w;
						end
						if (step_q == LAST_STEP) begin
							state_q <= C_FIN;
						end else begin
							step_q <= step_q + CORDIC_STEP_BITS'(1);
						end
					end
					C_FIN: begin
						cos_q   <= cos_n;
						sin_q   <= sin_n;
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end
					C_IDLE: begin
					end
					default: begin
						state_q <= C_IDLE;
					end
				endcase
			end
		end
	end

	assign cos_val = cos_q;
	assign sin_val = sin_q;
	assign done    = done_q;

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == C_RUN) |-> (step_q <= LAST_STEP))
		else $error("rotation step counter ran past the last step");

endmodule

FILE: rtl/core/scr_coef.sv
`timescale 1ns / 1ps

module scr_coef
	import scr_pkg::*;
#(
	parameter int COEFF_BITS = 18
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfg_write_t                   cfg,
	output logic                         busy,
	output logic signed [COEFF_BITS-1:0] mat [0:2][0:2]
);

	localparam int F  = COEFF_BITS - 1;
	localparam int PW = 2 * COEFF_BITS;
	localparam logic signed [COEFF_BITS-1:0] COEF_MAX = {1'b0, {F{1'b1}}};
	localparam logic signed [PW-1:0] CMAX_P = {{(PW-F){1'b0}}, {F{1'b1}}};
	localparam logic signed [PW-1:0] CMIN_P = -CMAX_P;
	localparam logic signed [PW-1:0] HALF_P = {{(PW-1){1'b0}}, 1'b1} << (F - 1);

	typedef enum logic [2:0] {S_IDLE, S_ANGLES, S_MUL, S_RND, S_MATRIX} coef_state_t;

	coef_state_t                  state_q;
	logic [MODE_BITS-1:0]         mode_q;
	logic [ANGLE_BITS-1:0]        baz_q;
	logic [ANGLE_BITS-1:0]        inc_q;
	logic                         start_q;
	logic [1:0]                   kidx_q;
	logic signed [PW-1:0]         prod_q;
	logic signed [COEFF_BITS-1:0] cross_q [0:3];
	logic signed [COEFF_BITS-1:0] mat_q [0:2][0:2];

	logic                         cfg_hit;
	logic signed [COEFF_BITS-1:0] cb;
	logic signed [COEFF_BITS-1:0] sb;
	logic signed [COEFF_BITS-1:0] ci;
	logic signed [COEFF_BITS-1:0] si;
	logic                         baz_done;
	logic                         inc_done;
	logic signed [COEFF_BITS-1:0] mul_a;
	logic signed [COEFF_BITS-1:0] mul_b;
	logic signed [PW-1:0]         rnd_w;
	logic signed [COEFF_BITS-1:0] rnd_c;
	logic signed [COEFF_BITS-1:0] mat_n [0:2][0:2];

	scr_cordic #(.COEFF_BITS(COEFF_BITS)) u_baz (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.angle   (baz_q),
		.cos_val (cb),
		.sin_val (sb),
		.done    (baz_done)
	);

	scr_cordic #(.COEFF_BITS(COEFF_BITS)) u_inc (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.angle   (inc_q),
		.cos_val (ci),
		.sin_val (si),
		.done    (inc_done)
	);

	assign cfg_hit = cfg.en && (cfg.index == REG_ROTATION_MODE ||
		cfg.index == REG_BACK_AZIMUTH || cfg.index == REG_INCIDENCE_ANGLE);

	always_comb begin
		case (kidx_q)
			2'd0: begin
				mul_a = si;
				mul_b = sb;
			end
			2'd1: begin
				mul_a = ci;
				mul_b = sb;
			end
			2'd2: begin
				mul_a = si;
				mul_b = cb;
			end
			default: begin
				mul_a = ci;
				mul_b = cb;
			end
		endcase
		rnd_w = (prod_q + HALF_P) >>> F;
		if (rnd_w > CMAX_P) begin
			rnd_c = COEF_MAX;
		end else if (rnd_w < CMIN_P) begin
			rnd_c = -COEF_MAX;
		end else begin
			rnd_c = rnd_w[COEFF_BITS-1:0];
		end
	end

	// Rows are the outputs a, b, c; columns are the input components a, b, c.
	// cross_q holds sin_inc*sin_baz, cos_inc*sin_baz, sin_inc*cos_baz, cos_inc*cos_baz.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				mat_n[r][k] = '0;
			end
		end
		case (rot_mode_t'(mode_q))
			MODE_NE_RT: begin
				mat_n[1][1] = -cb;
				mat_n[1][2] = -sb;
				mat_n[2][1] = sb;
				mat_n[2][2] = -cb;
			end
			MODE_RT_NE: begin
				mat_n[1][1] = -cb;
				mat_n[1][2] = sb;
				mat_n[2][1] = -sb;
				mat_n[2][2] = -cb;
			end
			MODE_ZNE_LQT: begin
				mat_n[0][0] = ci;
				mat_n[0][1] = -cross_q[2];
				mat_n[0][2] = -cross_q[0];
				mat_n[1][0] = -si;
				mat_n[1][1] = -cross_q[3];
				mat_n[1][2] = -cross_q[1];
				mat_n[2][1] = sb;
				mat_n[2][2] = -cb;
			end
			MODE_LQT_ZNE: begin
				mat_n[0][0] = ci;
				mat_n[0][1] = -si;
				mat_n[1][0] = -cross_q[2];
				mat_n[1][1] = -cross_q[3];
				mat_n[1][2] = sb;
				mat_n[2][0] = -cross_q[0];
				mat_n[2][1] = -cross_q[1];
				mat_n[2][2] = -cb;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= MODE_NE_RT;
			baz_q      <= '0;
			inc_q      <= '0;
			start_q    <= 1'b0;
			kidx_q     <= '0;
			prod_q     <= '0;
			cross_q[0] <= '0;
			cross_q[1] <= '0;
			cross_q[2] <= '0;
			cross_q[3] <= COEF_MAX - COEFF_BITS'(1);
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					mat_q[r][k] <= '0;
				end
			end
			mat_q[1][1] <= -COEF_MAX;
			mat_q[2][2] <= -COEF_MAX;
		end else begin
			start_q <= cfg_hit;
			if (cfg_hit) begin
				case (cfg.index)
					REG_ROTATION_MODE:   mode_q <= cfg.data[MODE_BITS-1:0];
					REG_BACK_AZIMUTH:    baz_q  <= cfg.data[ANGLE_BITS-1:0];
					REG_INCIDENCE_ANGLE: inc_q  <= cfg.data[ANGLE_BITS-1:0];
					default: begin
					end
				endcase
				state_q <= S_ANGLES;
			end else begin
				case (state_q)
					S_ANGLES: begin
						if (baz_done && inc_done && !start_q) begin
							kidx_q  <= '0;
							state_q <= S_MUL;
						end
					end
					S_MUL: begin
						prod_q  <= PW'(mul_a) * PW'(mul_b);
						state_q <= S_RND;
					end
					S_RND: begin
						cross_q[kidx_q] <= rnd_c;
						if (kidx_q == 2'd3) begin
							state_q <= S_MATRIX;
						end else begin
							kidx_q  <= kidx_q + 2'd1;
							state_q <= S_MUL;
						end
					end
					S_MATRIX: begin
						mat_q   <= mat_n;
						state_q <= S_IDLE;
					end
					S_IDLE: begin
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign mat  = mat_q;

endmodule

FILE: rtl/core/scr_datapath.sv
`timescale 1ns / 1ps

module scr_datapath
	import scr_pkg::*;
#(
	parameter int SAMPLE_BITS = 24,
	parameter int COEFF_BITS  = 18
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         busy,
	input  logic signed [COEFF_BITS-1:0] mat [0:2][0:2],
	scr_sample_if.sink                   samples,
	scr_result_if.source                 results
);

	localparam int F  = COEFF_BITS - 1;
	localparam int PB = SAMPLE_BITS + COEFF_BITS;
	localparam int SW = PB + 2;
	localparam logic signed [SW-1:0] HALF_S = {{(SW-1){1'b0}}, 1'b1} << (F - 1);
	localparam logic signed [SW-1:0] OUT_HI = {{(SW-SAMPLE_BITS+1){1'b0}},
		{(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SW-1:0] OUT_LO = ~OUT_HI;

	logic                          v1_q;
	logic                          v2_q;
	logic                          vo_q;
	logic                          rdy1;
	logic                          rdy2;
	logic                          rdy_o;

	logic signed [SAMPLE_BITS-1:0] smp_s1 [0:2];
	logic                          last_s1;
	logic signed [PB-1:0]          prod_s2 [0:2][0:2];
	logic                          last_s2;

	logic signed [SAMPLE_BITS-1:0] res_q [0:2];
	logic                          sat_q;
	logic                          last_q;

	logic signed [SW-1:0]          acc [0:2];
	logic signed [SW-1:0]          scaled [0:2];
	logic signed [SAMPLE_BITS-1:0] res_n [0:2];
	logic [2:0]                    clip;

	assign rdy_o = !vo_q || results.ready;
	assign rdy2  = !v2_q || rdy_o;
	assign rdy1  = !v1_q || rdy2;
	assign samples.ready = rdy1 && !busy;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = $signed({{2{prod_s2[r][0][PB-1]}}, prod_s2[r][0]})
				+ $signed({{2{prod_s2[r][1][PB-1]}}, prod_s2[r][1]})
				+ $signed({{2{prod_s2[r][2][PB-1]}}, prod_s2[r][2]})
				+ HALF_S;
			scaled[r] = acc[r] >>> F;
			if (scaled[r] > OUT_HI) begin
				res_n[r] = OUT_HI[SAMPLE_BITS-1:0];
				clip[r]  = 1'b1;
			end else if (scaled[r] < OUT_LO) begin
				res_n[r] = OUT_LO[SAMPLE_BITS-1:0];
				clip[r]  = 1'b1;
			end else begin
				res_n[r] = scaled[r][SAMPLE_BITS-1:0];
				clip[r]  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_q <= samples.valid && samples.ready;
			end
			if (rdy2) begin
				v2_q <= v1_q;
			end
			if (rdy_o) begin
				vo_q <= v2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			smp_s1[0] <= samples.comp_a;
			smp_s1[1] <= samples.comp_b;
			smp_s1[2] <= samples.comp_c;
			last_s1   <= samples.last_in;
		end
		if (v1_q && rdy2) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s2[r][k] <= PB'(smp_s1[k]) * PB'(mat[r][k]);
				end
			end
			last_s2 <= last_s1;
		end
		if (v2_q && rdy_o) begin
			res_q  <= res_n;
			sat_q  <= |clip;
			last_q <= last_s2;
		end
	end

	assign results.valid     = vo_q;
	assign results.out_a     = res_q[0];
	assign results.out_b     = res_q[1];
	assign results.out_c     = res_q[2];
	assign results.saturated = sat_q;
	assign results.last_out  = last_q;

	a_prod_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v2_q && !rdy_o) |=> (v2_q && $stable(last_s2)))
		else $error("product stage lost or changed a stalled sample");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import scr_pkg::*;

	localparam int SAMPLE_W = 24;
	localparam int FRAC = 17;
	localparam longint COEF_ONE = 131071;
	localparam longint SAMPLE_MAX = 8388607;
	localparam longint SAMPLE_MIN = -8388608;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;
	localparam logic [SAMPLE_W-1:0] S_MAX = 24'h7FFFFF;
	localparam logic [SAMPLE_W-1:0] S_MIN = 24'h800000;

	typedef struct {
		logic [SAMPLE_W-1:0] a;
		logic [SAMPLE_W-1:0] b;
		logic [SAMPLE_W-1:0] c;
		logic sat;
		logic last;
	} triple_t;

	class rotation_scoreboard;
		rot_mode_t mode;
		logic [15:0] baz_angle;
		logic [15:0] inc_angle;
		longint cos_az, sin_az, cos_in, sin_in;
		longint si_sb, ci_sb, si_cb, ci_cb;
		longint step_angle[24];
		triple_t pending[$];
		int errors;

		function new();
			step_angle = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
				10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
				41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
			mode = MODE_NE_RT;
			baz_angle = '0;
			inc_angle = '0;
			errors = 0;
			refresh_coeffs();
		endfunction

		function longint clamp_coef(longint v);
			if (v > COEF_ONE) begin
				return COEF_ONE;
			end
			if (v < -COEF_ONE) begin
				return -COEF_ONE;
			end
			return v;
		endfunction

		// Residual angle within a quadrant goes through the CORDIC, then the
		// quadrant bits swap and negate the pair.
		function void angle_trig(logic [15:0] ang, output longint c, output longint s);
			longint x, y, cx, cy, z, dx, dy;
			x = COEF_ONE;
			y = 0;
			if (ang[13:0] != 0) begin
				cx = 652032874;
				cy = 0;
				z = longint'(ang[13:0]) * 65536;
				for (int i = 0; i < 24; i++) begin
					dx = cy >>> i;
					dy = cx >>> i;
					if (z >= 0) begin
						cx -= dx;
						cy += dy;
						z -= step_angle[i];
					end else begin
						cx += dx;
						cy -= dy;
						z += step_angle[i];
					end
				end
				x = clamp_coef((cx + 4096) >>> 13);
				y = clamp_coef((cy + 4096) >>> 13);
			end
			case (ang[15:14])
				2'd0: begin
					c = x;
					s = y;
				end
				2'd1: begin
					c = -y;
					s = x;
				end
				2'd2: begin
					c = -x;
					s = -y;
				end
				default: begin
					c = y;
					s = -x;
				end
			endcase
		endfunction

		function longint coef_product(longint p, longint q);
			return clamp_coef((p * q + 65536) >>> FRAC);
		endfunction

		function void refresh_coeffs();
			angle_trig(baz_angle, cos_az, sin_az);
			angle_trig(inc_angle, cos_in, sin_in);
			si_sb = coef_product(sin_in, sin_az);
			ci_sb = coef_product(cos_in, sin_az);
			si_cb = coef_product(sin_in, cos_az);
			ci_cb = coef_product(cos_in, cos_az);
		endfunction

		function void apply_write(logic [CFG_INDEX_BITS-1:0] index, logic [15:0] data);
			case (index)
				REG_ROTATION_MODE: mode = rot_mode_t'(data[1:0]);
				REG_BACK_AZIMUTH: baz_angle = data;
				REG_INCIDENCE_ANGLE: inc_angle = data;
				default: return;
			endcase
			refresh_coeffs();
		endfunction

		function logic [SAMPLE_W-1:0] round_sample(longint acc, inout bit sat);
			longint v;
			v = (acc + 65536) >>> FRAC;
			if (v > SAMPLE_MAX) begin
				v = SAMPLE_MAX;
				sat = 1'b1;
			end
			if (v < SAMPLE_MIN) begin
				v = SAMPLE_MIN;
				sat = 1'b1;
			end
			return v[SAMPLE_W-1:0];
		endfunction

		function void note_sample(logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b,
			logic signed [SAMPLE_W-1:0] c, logic last);
			longint za, zb, zc, ra, rb, rc;
			bit sat;
			triple_t t;
			za = a;
			zb = b;
			zc = c;
			ra = 0;
			sat = 1'b0;
			case (mode)
				MODE_NE_RT: begin
					rb = -cos_az * zb - sin_az * zc;
					rc = sin_az * zb - cos_az * zc;
				end
				MODE_RT_NE: begin
					rb = -cos_az * zb + sin_az * zc;
					rc = -sin_az * zb - cos_az * zc;
				end
				MODE_ZNE_LQT: begin
					ra = cos_in * za - si_sb * zc - si_cb * zb;
					rb = -sin_in * za - ci_sb * zc - ci_cb * zb;
					rc = -cos_az * zc + sin_az * zb;
				end
				default: begin
					ra = cos_in * za - sin_in * zb;
					rb = -si_cb * za - ci_cb * zb + sin_az * zc;
					rc = -si_sb * za - ci_sb * zb - cos_az * zc;
				end
			endcase
			t.a = '0;
			if (mode == MODE_ZNE_LQT || mode == MODE_LQT_ZNE) begin
				t.a = round_sample(ra, sat);
			end
			t.b = round_sample(rb, sat);
			t.c = round_sample(rc, sat);
			t.sat = sat;
			t.last = last;
			pending.push_back(t);
		endfunction

		function void compare(string field, logic [SAMPLE_W-1:0] want, logic [SAMPLE_W-1:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field,
					$signed(want), $signed(got));
				errors++;
			end
		endfunction

		function void check_triple(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
			logic [SAMPLE_W-1:0] c, logic sat, logic last);
			triple_t e;
			if (pending.size() == 0) begin
				$display("%0t: result transfer with nothing pending, expected none, actual %0d %0d %0d",
					$time, $signed(a), $signed(b), $signed(c));
				errors++;
				return;
			end
			e = pending.pop_front();
			compare("out_a", e.a, a);
			compare("out_b", e.b, b);
			compare("out_c", e.c, c);
			compare("saturated", SAMPLE_W'(e.sat), SAMPLE_W'(sat));
			compare("last_out", SAMPLE_W'(e.last), SAMPLE_W'(last));
		endfunction

		function int outstanding();
			return pending.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	bit long_hold_req;
	logic [15:0] corner_angles[8] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
		16'hC000, 16'h0001, 16'h3FFF, 16'h2000};

	rotation_scoreboard board = new();

	scr_sample_if #(.SAMPLE_BITS(SAMPLE_W)) samples_ch ();
	scr_result_if #(.SAMPLE_BITS(SAMPLE_W)) results_ch ();

	seismic_component_rotator_unit #(
		.SAMPLE_BITS(SAMPLE_W),
		.COEFF_BITS(18)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.samples(samples_ch),
		.results(results_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (samples_ch.valid && samples_ch.ready) begin
				board.note_sample(samples_ch.comp_a, samples_ch.comp_b, samples_ch.comp_c,
					samples_ch.last_in);
			end
			if (results_ch.valid && results_ch.ready) begin
				board.check_triple(results_ch.out_a, results_ch.out_b, results_ch.out_c,
					results_ch.saturated, results_ch.last_out);
			end
		end
	end

	initial begin
		results_ch.ready = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				results_ch.ready <= 1'b0;
				repeat (80) @(posedge clk);
			end else begin
				case ($urandom_range(0, 5))
					0, 1: begin
						results_ch.ready <= 1'b1;
						repeat ($urandom_range(1, 40)) @(posedge clk);
					end
					2, 3: begin
						repeat ($urandom_range(1, 30)) begin
							results_ch.ready <= 1'($urandom_range(0, 1));
							@(posedge clk);
						end
					end
					4: begin
						results_ch.ready <= 1'b0;
						repeat ($urandom_range(1, 6)) @(posedge clk);
					end
					default: begin
						repeat ($urandom_range(1, 30)) begin
							results_ch.ready <= ($urandom_range(0, 3) != 0);
							@(posedge clk);
						end
					end
				endcase
			end
		end
	end

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return S_MAX;
			1: return S_MIN;
			2: return SAMPLE_W'($urandom_range(0, 32)) - SAMPLE_W'(16);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.apply_write(index, data);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (board.outstanding() != 0) @(posedge clk);
	endtask

	task automatic configure(rot_mode_t m, logic [15:0] baz, logic [15:0] inc);
		logic [CFG_DATA_BITS-1:0] mode_word;
		mode_word = CFG_DATA_BITS'($urandom());
		mode_word[1:0] = m;
		wait_drained();
		write_reg(REG_ROTATION_MODE, mode_word);
		write_reg(REG_BACK_AZIMUTH, baz);
		write_reg(REG_INCIDENCE_ANGLE, inc);
	endtask

	// Leaves valid high; the caller lowers it when the burst ends.
	task automatic send_item(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
		logic [SAMPLE_W-1:0] c, logic last);
		samples_ch.valid <= 1'b1;
		samples_ch.comp_a <= a;
		samples_ch.comp_b <= b;
		samples_ch.comp_c <= c;
		samples_ch.last_in <= last;
		do @(posedge clk); while (!samples_ch.ready);
	endtask

	task automatic send_extremes();
		send_item(S_MAX, S_MAX, S_MAX, 1'b0);
		send_item(S_MIN, S_MIN, S_MIN, 1'b1);
		send_item(S_MAX, S_MIN, S_MAX, 1'b0);
		send_item('0, '0, '0, 1'b1);
		send_item('1, SAMPLE_W'(1), '1, 1'b0);
		samples_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_stream(int count);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && sent < count) begin
				send_item(pick_sample(), pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
				sent++;
				burst--;
			end
			if (sent < count && $urandom_range(0, 3) != 0) begin
				samples_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		samples_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		long_hold_req = 1'b0;
		samples_ch.valid = 1'b0;
		samples_ch.comp_a = '0;
		samples_ch.comp_b = '0;
		samples_ch.comp_c = '0;
		samples_ch.last_in = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_extremes();
		for (int m = 0; m < 4; m++) begin
			configure(rot_mode_t'(m), 16'h2000, 16'h6000);
			send_extremes();
		end

		for (int p = 0; p < 14; p++) begin
			if (p < 8) begin
				configure(rot_mode_t'(p % 4), corner_angles[p], corner_angles[7 - p]);
			end else begin
				configure(rot_mode_t'($urandom_range(0, 3)), 16'($urandom()), 16'($urandom()));
			end
			if (p == 5) begin
				write_reg(REG_SPARE, CFG_DATA_BITS'($urandom()));
			end
			if (p == 2) begin
				long_hold_req = 1'b1;
			end
			send_stream(64);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (board.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
